// ----- rtl/core/sdtp_pkg.sv -----
// Shared types, constants and slot packing for the scale-degree template packer.
package sdtp_pkg;

	localparam int WORD_SLOTS        = 8;
	localparam int DEFAULT_MAX_SLOTS = 8;

	localparam logic [3:0] REST_NIBBLE = 4'hF;
	localparam logic [4:0] OCTAVE      = 5'd12;
	localparam logic [3:0] ACC_TOP     = 4'd11;

	localparam logic [7:0] CHAR_SEPARATOR = 8'h2D;
	localparam logic [7:0] CHAR_FLAT      = 8'h62;
	localparam logic [7:0] CHAR_SHARP     = 8'h23;
	localparam logic [7:0] CHAR_ONE       = 8'h31;
	localparam logic [7:0] CHAR_SEVEN     = 8'h37;

	typedef struct packed {
		logic [3:0] acc;
		logic       decided;
		logic       started;
		logic [3:0] nibble;
	} tok_t;

	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  count;
	} pack_t;

	localparam tok_t TOK_CLEAR = '{acc: 4'd0, decided: 1'b0, started: 1'b0,
		nibble: REST_NIBBLE};
	localparam pack_t PACK_CLEAR = '{word: 32'd0, count: 4'd0};

	function automatic logic [3:0] major_semitone(input logic [2:0] degree);
		logic [3:0] semi;
		case (degree)
			3'd2:    semi = 4'd2;
			3'd3:    semi = 4'd4;
			3'd4:    semi = 4'd5;
			3'd5:    semi = 4'd7;
			3'd6:    semi = 4'd9;
			3'd7:    semi = 4'd11;
			default: semi = 4'd0;
		endcase
		return semi;
	endfunction

	// Append the current token to the packed word if it holds characters and room is left.
	function automatic pack_t close_token(input pack_t p, input tok_t t,
		input logic [3:0] limit);
		pack_t      r;
		logic [3:0] nib;
		r   = p;
		nib = t.decided ? t.nibble : REST_NIBBLE;
		if (t.started && (p.count < limit) && (p.count < 4'(WORD_SLOTS))) begin
			r.word  = p.word | (32'(nib) << {p.count[2:0], 2'b00});
			r.count = p.count + 4'd1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/sdtp_char_step.sv -----
// One character step: accidentals, degree decode and token close on a dash.
module sdtp_char_step #(
	parameter int MAX_SLOTS = sdtp_pkg::DEFAULT_MAX_SLOTS
) (
	input  sdtp_pkg::tok_t  tok_cur,
	input  sdtp_pkg::pack_t pack_cur,
	input  logic            has_char,
	input  logic [7:0]      char_code,
	output sdtp_pkg::tok_t  tok_nxt,
	output sdtp_pkg::pack_t pack_nxt
);
	import sdtp_pkg::*;

	localparam logic [3:0] SLOT_LIMIT =
		4'((MAX_SLOTS > WORD_SLOTS) ? WORD_SLOTS : MAX_SLOTS);

	logic [4:0] semi_sum;

	assign semi_sum = 5'(major_semitone(char_code[2:0])) + 5'(tok_cur.acc);

	always_comb begin
		tok_nxt  = tok_cur;
		pack_nxt = pack_cur;
		if (has_char) begin
			if (char_code == CHAR_SEPARATOR) begin
				pack_nxt = close_token(pack_cur, tok_cur, SLOT_LIMIT);
				tok_nxt  = TOK_CLEAR;
			end else begin
				tok_nxt.started = 1'b1;
				if (!tok_cur.decided) begin
					if (char_code == CHAR_FLAT) begin
						tok_nxt.acc = (tok_cur.acc == 4'd0) ? ACC_TOP : tok_cur.acc - 4'd1;
					end else if (char_code == CHAR_SHARP) begin
						tok_nxt.acc = (tok_cur.acc == ACC_TOP) ? 4'd0 : tok_cur.acc + 4'd1;
					end else begin
						tok_nxt.decided = 1'b1;
						if (char_code >= CHAR_ONE && char_code <= CHAR_SEVEN) begin
							tok_nxt.nibble = (semi_sum >= OCTAVE) ? 4'(semi_sum - OCTAVE)
								: semi_sum[3:0];
						end else begin
							tok_nxt.nibble = REST_NIBBLE;
						end
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/scale_degree_template_packer.sv -----
// Top level: parses a scale-degree string one character per item, packs 4-bit slots.
// The result is registered: it appears the cycle after the item that ends the string is accepted.
// Throughput: one item per cycle; a new item may enter in the cycle that a held result is
// taken, and input stalls only while a held result is not taken.
// Reset: token state cleared to rest, packed word and slot count zero, no result held.
module scale_degree_template_packer #(
	parameter int MAX_SLOTS = sdtp_pkg::DEFAULT_MAX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        has_char,
	input  logic [7:0]  char_code,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_template,
	output logic [3:0]  tokens_packed
);
	import sdtp_pkg::*;

	localparam logic [3:0] SLOT_LIMIT =
		4'((MAX_SLOTS > WORD_SLOTS) ? WORD_SLOTS : MAX_SLOTS);

	tok_t        tok_q;
	pack_t       pack_q;
	tok_t        tok_step;
	pack_t       pack_step;
	pack_t       pack_fin;
	logic [31:0] word_fill;
	logic        accept;
	logic        out_valid_q;
	logic [31:0] packed_template_q;
	logic [3:0]  tokens_packed_q;

	sdtp_char_step #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_char_step (
		.tok_cur  (tok_q),
		.pack_cur (pack_q),
		.has_char (has_char),
		.char_code(char_code),
		.tok_nxt  (tok_step),
		.pack_nxt (pack_step)
	);

	assign pack_fin = close_token(pack_step, tok_step, SLOT_LIMIT);

	always_comb begin
		for (int k = 0; k < WORD_SLOTS; k++) begin
			word_fill[4*k +: 4] = (4'(k) < pack_fin.count) ? pack_fin.word[4*k +: 4]
				: REST_NIBBLE;
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= TOK_CLEAR;
			pack_q      <= PACK_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (end_of_string) begin
					tok_q       <= TOK_CLEAR;
					pack_q      <= PACK_CLEAR;
					out_valid_q <= 1'b1;
				end else begin
					tok_q  <= tok_step;
					pack_q <= pack_step;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_string) begin
			packed_template_q <= word_fill;
			tokens_packed_q   <= pack_fin.count;
		end
	end

	assign out_valid       = out_valid_q;
	assign packed_template = packed_template_q;
	assign tokens_packed   = tokens_packed_q;

endmodule

// ----- sim/sdtp_checker.sv -----
// Checker for the scale-degree template packer: tracks accepted items and compares each result.
`timescale 1ns / 1ps

module sdtp_checker #(
	parameter int MAX_SLOTS = sdtp_pkg::DEFAULT_MAX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        has_char,
	input  logic [7:0]  char_code,
	input  logic        end_of_string,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] packed_template,
	input  logic [3:0]  tokens_packed,
	output int          errors,
	output int          waiting
);
	import sdtp_pkg::*;

	localparam int SLOT_CAP = (MAX_SLOTS > WORD_SLOTS) ? WORD_SLOTS : MAX_SLOTS;

	logic [3:0]  tok_acc;
	logic        tok_decided;
	logic        tok_started;
	logic [3:0]  tok_pitch;
	logic [31:0] slots_word;
	logic [3:0]  slots_used;
	pack_t       templates_due[$];
	pack_t       due;
	pack_t       seen;

	task start_new_token;
		tok_acc     = 4'd0;
		tok_decided = 1'b0;
		tok_started = 1'b0;
		tok_pitch   = REST_NIBBLE;
	endtask

	task commit_token;
		if (tok_started && slots_used < SLOT_CAP) begin
			slots_word = slots_word |
				(32'(tok_decided ? tok_pitch : REST_NIBBLE) << (4 * slots_used));
			slots_used = slots_used + 4'd1;
		end
		start_new_token();
	endtask

	task parse_char(input logic [7:0] c);
		logic [3:0] semi;
		logic [4:0] sum;
		if (c == CHAR_SEPARATOR) begin
			commit_token();
		end else begin
			tok_started = 1'b1;
			if (!tok_decided) begin
				if (c == CHAR_FLAT) begin
					tok_acc = (tok_acc == 4'd0) ? ACC_TOP : tok_acc - 4'd1;
				end else if (c == CHAR_SHARP) begin
					tok_acc = (tok_acc == ACC_TOP) ? 4'd0 : tok_acc + 4'd1;
				end else begin
					tok_decided = 1'b1;
					if (c >= CHAR_ONE && c <= CHAR_SEVEN) begin
						case (c[2:0])
							3'd2:    semi = 4'd2;
							3'd3:    semi = 4'd4;
							3'd4:    semi = 4'd5;
							3'd5:    semi = 4'd7;
							3'd6:    semi = 4'd9;
							3'd7:    semi = 4'd11;
							default: semi = 4'd0;
						endcase
						sum = 5'(semi) + 5'(tok_acc);
						if (sum >= OCTAVE)
							sum = sum - OCTAVE;
						tok_pitch = sum[3:0];
					end else begin
						tok_pitch = REST_NIBBLE;
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_new_token();
			slots_word = 32'd0;
			slots_used = 4'd0;
			templates_due.delete();
			errors = 0;
			waiting <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (has_char)
					parse_char(char_code);
				if (end_of_string) begin
					commit_token();
					due.word  = slots_word;
					due.count = slots_used;
					for (int k = slots_used; k < WORD_SLOTS; k++)
						due.word = due.word | (32'(REST_NIBBLE) << (4 * k));
					templates_due.insert(templates_due.size(), due);
					start_new_token();
					slots_word = 32'd0;
					slots_used = 4'd0;
				end
			end
			if (out_valid && out_ready) begin
				seen.word  = packed_template;
				seen.count = tokens_packed;
				if (templates_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h / %0d",
						$time, seen.word, seen.count);
				end else begin
					due = templates_due.pop_front();
					if (seen.word !== due.word) begin
						errors++;
						$display("%0t: packed_template expected %h, got %h",
							$time, due.word, seen.word);
					end
					if (seen.count !== due.count) begin
						errors++;
						$display("%0t: tokens_packed expected %0d, got %0d",
							$time, due.count, seen.count);
					end
				end
			end
			waiting <= templates_due.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the scale-degree template packer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import sdtp_pkg::*;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        has_char      = 1'b0;
	logic [7:0]  char_code     = 8'd0;
	logic        end_of_string = 1'b0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [31:0] packed_template;
	logic [3:0]  tokens_packed;

	int          errors;
	int          waiting;
	int          items_sent = 0;
	bit          calm       = 1'b0;
	logic [7:0]  text[$];

	always #1 clk = ~clk;

	scale_degree_template_packer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.has_char        (has_char),
		.char_code       (char_code),
		.end_of_string   (end_of_string),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.packed_template (packed_template),
		.tokens_packed   (tokens_packed)
	);

	sdtp_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.has_char        (has_char),
		.char_code       (char_code),
		.end_of_string   (end_of_string),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.packed_template (packed_template),
		.tokens_packed   (tokens_packed),
		.errors          (errors),
		.waiting         (waiting)
	);

	initial begin
		#200000;
		$display("tb_top: done, errors");
		$finish;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 27);

	task automatic send_item(input logic hc, input logic [7:0] c, input logic eos);
		in_valid      <= 1'b1;
		has_char      <= hc;
		char_code     <= c;
		end_of_string <= eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (hc || eos)
			items_sent++;
		if (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2))
				@(posedge clk);
		end
	endtask

	function automatic void append_char(input logic [7:0] c);
		text.insert(text.size(), c);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endfunction

	// Sends the queued string; the end mark rides on the last char or on a bare item.
	task automatic send_text(input bit bare_end);
		int n;
		n = text.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 3)
				send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			send_item(1'b1, text[i], !bare_end && i == n - 1);
		end
		if (bare_end || n == 0)
			send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		text.delete();
	endtask

	task automatic add_token;
		int         n;
		logic [7:0] c;
		n = $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(4, 15);
		repeat (n)
			append_char($urandom_range(0, 1) ? CHAR_FLAT : CHAR_SHARP);
		case ($urandom_range(0, 9))
			0: ;
			1: begin
				c = 8'h38 + 8'($urandom_range(0, 2));
				append_char((c == 8'h3A) ? 8'h30 : c);
			end
			2: begin
				c = 8'($urandom_range(0, 255));
				append_char((c == CHAR_SEPARATOR) ? 8'h00 : c);
			end
			default: append_char(CHAR_ONE + 8'($urandom_range(0, 6)));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				c = 8'($urandom_range(0, 255));
				append_char((c == CHAR_SEPARATOR) ? CHAR_FLAT : c);
			end
		end
	endtask

	task automatic add_random_string;
		int tokens;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				append_char(($urandom_range(0, 3) == 0) ? CHAR_SEPARATOR :
					8'($urandom_range(0, 255)));
		end else begin
			tokens = $urandom_range(0, 11);
			if ($urandom_range(0, 9) == 0)
				append_char(CHAR_SEPARATOR);
			for (int t = 0; t < tokens; t++) begin
				add_token();
				if (t < tokens - 1) begin
					append_char(CHAR_SEPARATOR);
					if ($urandom_range(0, 14) == 0)
						append_char(CHAR_SEPARATOR);
				end
			end
			if ($urandom_range(0, 9) == 0)
				append_char(CHAR_SEPARATOR);
		end
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain string, end mark on the last char
		add_text("1-b3-5");
		send_text(1'b0);
		// empty string
		send_text(1'b1);
		// leading dash, accidentals only, out-of-range degree, trailing junk, repeated dash
		add_text("-#-8");
		append_char(8'hFF);
		add_text("--");
		for (int i = 0; i < text.size(); i++)
			send_item(1'b1, text[i], 1'b0);
		text.delete();
		send_item(1'b0, 8'h00, 1'b0);
		send_item(1'b0, 8'hFF, 1'b1);
		// NUL rest, trailing accidental ignored, sharp wrapping to zero
		append_char(8'h00);
		add_text("-b1#-#7");
		send_text(1'b0);

		while (items_sent < 700) begin
			calm = (items_sent >= 250 && items_sent < 400);
			add_random_string();
			send_text($urandom_range(0, 3) == 0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
